/* rtl/core/assert_macros.svh */
// Assertion macros for the orthogonaliser RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define GSQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, also checked while reset is applied.
`define GSQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/gsq_pkg.sv */
// Shared constants for the Gram-Schmidt orthogonaliser.
// No dependencies; imported by the divider and the top level.
package gsq_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] MODE_SECOND = 2'd0;
  localparam logic [1:0] MODE_THIRD  = 2'd1;
  localparam logic [1:0] MODE_BOTH   = 2'd2;
  // The remaining code has no meaning; both vectors pass through unchanged.
  localparam logic [1:0] MODE_PASS   = 2'd3;

endpackage

/* rtl/core/gsq_div.sv */
// Pipelined projection-coefficient divider, one quotient bit per bit stage.
// Depends on gsq_pkg for parameter defaults.
module gsq_div import gsq_pkg::*; #(
  parameter int W    = DATA_WIDTH_DEF,
  parameter int F    = FRAC_BITS_DEF,
  parameter int SB_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [2*W+1:0] num_i,
  input  logic [2*W+1:0]        den_i,
  input  logic [SB_W-1:0]       sb_i,
  output logic                  out_valid,
  output logic signed [W-1:0]   coef_o,
  output logic                  zero_o,
  output logic [SB_W-1:0]       sb_o
);

  localparam int DW = 2 * W + 2;
  localparam int NW = DW + F;
  localparam int QW = W - 1;
  localparam int NS = W - 1;

  localparam logic [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

  // Front stage: magnitude and scaled numerator.
  logic            va_r;
  logic [NW-1:0]   nsh_r;
  logic [DW-1:0]   den_a_r;
  logic            neg_a_r;
  logic            zero_a_r;
  logic [SB_W-1:0] sb_a_r;

  logic [DW-1:0]   mag;

  // Bit stages: index 0 holds the state after the overflow test.
  logic            v_r    [0:NS];
  logic [DW-1:0]   rem_r  [0:NS];
  logic [QW-1:0]   q_r    [0:NS];
  logic [QW-1:0]   lo_r   [0:NS];
  logic [DW-1:0]   den_r  [0:NS];
  logic            neg_r  [0:NS];
  logic            zero_r [0:NS];
  logic            ovf_r  [0:NS];
  logic [SB_W-1:0] sb_r   [0:NS];

  logic [DW-1:0]   rem_nxt [0:NS-1];
  logic [QW-1:0]   q_nxt   [0:NS-1];

  logic            vo_r;
  logic [W-1:0]    coef_r;
  logic            zo_r;
  logic [SB_W-1:0] sbo_r;
  logic [W-1:0]    qpos;
  logic [W-1:0]    coef_nxt;

  assign mag = num_i[DW-1] ? DW'(-num_i) : DW'(num_i);

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      logic [DW:0] shifted;
      logic [DW:0] diff;
      logic        ge;
      shifted    = {rem_r[k], lo_r[k][QW-1]};
      diff       = shifted - {1'b0, den_r[k]};
      ge         = shifted >= {1'b0, den_r[k]};
      rem_nxt[k] = ge ? diff[DW-1:0] : shifted[DW-1:0];
      q_nxt[k]   = {q_r[k][QW-2:0], ge};
    end
  end

  assign qpos = {1'b0, q_r[NS]};

  always_comb begin
    if (zero_r[NS]) begin
      coef_nxt = '0;
    end else if (ovf_r[NS]) begin
      coef_nxt = neg_r[NS] ? C_MIN : C_MAX;
    end else begin
      coef_nxt = neg_r[NS] ? W'(-qpos) : qpos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k <= NS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      va_r   <= in_valid;
      v_r[0] <= va_r;
      for (int k = 0; k < NS; k++) v_r[k+1] <= v_r[k];
      vo_r   <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nsh_r    <= NW'(mag) << F;
      den_a_r  <= den_i;
      neg_a_r  <= num_i[DW-1];
      zero_a_r <= (den_i == '0);
      sb_a_r   <= sb_i;

      // A quotient of 2^(W-1) or more saturates; the bit stages then run idle.
      ovf_r[0]  <= (nsh_r >> (W-1)) >= NW'(den_a_r);
      rem_r[0]  <= DW'(nsh_r >> (W-1));
      lo_r[0]   <= nsh_r[QW-1:0];
      q_r[0]    <= '0;
      den_r[0]  <= den_a_r;
      neg_r[0]  <= neg_a_r;
      zero_r[0] <= zero_a_r;
      sb_r[0]   <= sb_a_r;

      for (int k = 0; k < NS; k++) begin
        rem_r[k+1]  <= rem_nxt[k];
        q_r[k+1]    <= q_nxt[k];
        lo_r[k+1]   <= lo_r[k] << 1;
        den_r[k+1]  <= den_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        ovf_r[k+1]  <= ovf_r[k];
        sb_r[k+1]   <= sb_r[k];
      end

      coef_r <= coef_nxt;
      zo_r   <= zero_r[NS];
      sbo_r  <= sb_r[NS];
    end
  end

  assign out_valid = vo_r;
  assign coef_o    = $signed(coef_r);
  assign zero_o    = zo_r;
  assign sb_o      = sbo_r;

endmodule

/* rtl/core/gram_schmidt_3d_orthogonalizer.sv */
// Top level of the classical Gram-Schmidt orthogonaliser for three 3D vectors.
// Depends on gsq_pkg, gsq_div and assert_macros.svh.
//
// Usage:
// The input channel (in_valid, in_stall) carries a mode and three vectors in
// signed fixed point; the result channel (out_valid, out_stall) carries the
// corrected second and third vectors and a degenerate flag. One result
// transaction follows each input transaction, in order.
// Eight arithmetic stages surround two coefficient dividers of DATA_WIDTH + 2
// stages, each resolving one quotient bit per bit stage. The dividers run one
// after the other because the third vector's second coefficient needs the
// corrected second vector.
// Throughput is one transaction per cycle when not stalled; every stage is
// fully pipelined. The whole pipeline advances together. While a result waits
// with out_stall high, the pipeline holds and in_stall is raised; nothing is
// lost or repeated. A waiting result is replaced in the same cycle it is taken.
// Reset (rst_n low, synchronous) clears all valid bits; data is not cleared.
`include "assert_macros.svh"

module gram_schmidt_3d_orthogonalizer import gsq_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_first_x,
  input  logic signed [DATA_WIDTH-1:0] in_first_y,
  input  logic signed [DATA_WIDTH-1:0] in_first_z,
  input  logic signed [DATA_WIDTH-1:0] in_second_x,
  input  logic signed [DATA_WIDTH-1:0] in_second_y,
  input  logic signed [DATA_WIDTH-1:0] in_second_z,
  input  logic signed [DATA_WIDTH-1:0] in_third_x,
  input  logic signed [DATA_WIDTH-1:0] in_third_y,
  input  logic signed [DATA_WIDTH-1:0] in_third_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_second_x,
  output logic signed [DATA_WIDTH-1:0] out_second_y,
  output logic signed [DATA_WIDTH-1:0] out_second_z,
  output logic signed [DATA_WIDTH-1:0] out_third_x,
  output logic signed [DATA_WIDTH-1:0] out_third_y,
  output logic signed [DATA_WIDTH-1:0] out_third_z,
  output logic                         out_degenerate
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 2;
  localparam int XW = 2 * W + 4;

  localparam logic signed [XW-1:0] SAT_MAX = (XW'(1) <<< (W-1)) - XW'(1);
  localparam logic signed [XW-1:0] SAT_MIN = -(XW'(1) <<< (W-1));

  function automatic logic [W-1:0] sat_w(input logic signed [XW-1:0] a);
    if (a > SAT_MAX) begin
      sat_w = SAT_MAX[W-1:0];
    end else if (a < SAT_MIN) begin
      sat_w = SAT_MIN[W-1:0];
    end else begin
      sat_w = a[W-1:0];
    end
  endfunction

  // Arithmetic shift right by the fraction bits, rounding toward zero.
  function automatic logic signed [XW-1:0] trunc_shr(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] adj;
    adj       = p[PW-1] ? p + PW'((1 << F) - 1) : p;
    trunc_shr = XW'(adj >>> F);
  endfunction

  function automatic logic signed [PW-1:0] mul_w(input logic [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    mul_w = PW'($signed(a)) * PW'(b);
  endfunction

  typedef logic [2:0][W-1:0]  vec_t;
  typedef logic [2:0][XW-1:0] wvec_t;

  logic en;
  logic do_s4, do_t4, do_t8, do_t9;

  // Stage 1: component products.
  logic                 v1_r;
  logic [1:0]           mode1_r;
  vec_t                 f1_r, s1_r, t1_r;
  logic signed [PW-1:0] pff1_r [3];
  logic signed [PW-1:0] psf1_r [3];
  logic signed [PW-1:0] ptf1_r [3];
  vec_t                 f_in, s_in, t_in;

  // Stage 2: dot products against the first vector.
  logic                 v2_r;
  logic [1:0]           mode2_r;
  vec_t                 f2_r, s2_r, t2_r;
  logic signed [DW-1:0] dff2_r, dsf2_r, dtf2_r;

  // First divider pass.
  logic                 v3;
  logic signed [W-1:0]  c0_3, c1_3;
  logic                 ffz3;
  vec_t                 f3, s3, t3;
  logic [1:0]           mode3;
  logic [3*W+1:0]       sb1b_o;

  // Stage 4: correction products against the first vector.
  logic                 v4_r;
  logic [1:0]           mode4_r;
  vec_t                 s4_r, t4_r;
  logic                 ffz4_r;
  logic signed [PW-1:0] pfc0_4_r [3];
  logic signed [PW-1:0] pfc1_4_r [3];

  // Stage 5: corrected second vector and partial third vector.
  logic                 v5_r;
  logic [1:0]           mode5_r;
  vec_t                 os5_r, t5_r;
  wvec_t                acc5_r;
  logic                 deg5_r;

  // Stage 6: products against the corrected second vector.
  logic                 v6_r;
  logic [1:0]           mode6_r;
  vec_t                 os6_r, t6_r;
  wvec_t                acc6_r;
  logic                 deg6_r;
  logic signed [PW-1:0] poo6_r [3];
  logic signed [PW-1:0] pto6_r [3];

  // Stage 7: dot products against the corrected second vector.
  logic                 v7_r;
  logic [1:0]           mode7_r;
  vec_t                 os7_r, t7_r;
  wvec_t                acc7_r;
  logic                 deg7_r;
  logic signed [DW-1:0] doo7_r, dto7_r;

  // Second divider pass.
  logic                 v8;
  logic signed [W-1:0]  c2_8;
  logic                 ooz8;
  vec_t                 os8, t8;
  wvec_t                acc8;
  logic [1:0]           mode8;
  logic                 deg8;

  // Stage 9: correction products against the corrected second vector.
  logic                 v9_r;
  logic [1:0]           mode9_r;
  vec_t                 os9_r, t9_r;
  wvec_t                acc9_r;
  logic                 deg9_r;
  logic signed [PW-1:0] pc2_9_r [3];

  // Stage 10: result register.
  logic                 out_valid_r;
  vec_t                 os_out_r, ot_out_r;
  logic                 deg_out_r;

  assign in_stall = out_valid_r && out_stall;
  assign en       = !in_stall;

  assign f_in = {in_first_z,  in_first_y,  in_first_x};
  assign s_in = {in_second_z, in_second_y, in_second_x};
  assign t_in = {in_third_z,  in_third_y,  in_third_x};

  assign do_s4 = (mode4_r == MODE_SECOND) || (mode4_r == MODE_BOTH);
  assign do_t4 = (mode4_r == MODE_THIRD)  || (mode4_r == MODE_BOTH);
  assign do_t8 = (mode8   == MODE_THIRD)  || (mode8   == MODE_BOTH);
  assign do_t9 = (mode9_r == MODE_THIRD)  || (mode9_r == MODE_BOTH);

  gsq_div #(.W(W), .F(F), .SB_W(6*W)) u_div1a (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .num_i     (dsf2_r),
    .den_i     (dff2_r),
    .sb_i      ({s2_r, f2_r}),
    .out_valid (v3),
    .coef_o    (c0_3),
    .zero_o    (ffz3),
    .sb_o      ({s3, f3})
  );

  gsq_div #(.W(W), .F(F), .SB_W(3*W+2)) u_div1b (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .num_i     (dtf2_r),
    .den_i     (dff2_r),
    .sb_i      ({t2_r, mode2_r}),
    .out_valid (),
    .coef_o    (c1_3),
    .zero_o    (),
    .sb_o      (sb1b_o)
  );

  assign {t3, mode3} = sb1b_o;

  gsq_div #(.W(W), .F(F), .SB_W(6*W+3*XW+3)) u_div2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v7_r),
    .num_i     (dto7_r),
    .den_i     (doo7_r),
    .sb_i      ({os7_r, acc7_r, t7_r, mode7_r, deg7_r}),
    .out_valid (v8),
    .coef_o    (c2_8),
    .zero_o    (ooz8),
    .sb_o      ({os8, acc8, t8, mode8, deg8})
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v9_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v4_r        <= v3;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v9_r        <= v8;
      out_valid_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= in_mode;
      f1_r    <= f_in;
      s1_r    <= s_in;
      t1_r    <= t_in;
      for (int i = 0; i < 3; i++) begin
        pff1_r[i] <= mul_w(f_in[i], $signed(f_in[i]));
        psf1_r[i] <= mul_w(s_in[i], $signed(f_in[i]));
        ptf1_r[i] <= mul_w(t_in[i], $signed(f_in[i]));
      end

      mode2_r <= mode1_r;
      f2_r    <= f1_r;
      s2_r    <= s1_r;
      t2_r    <= t1_r;
      dff2_r  <= DW'(pff1_r[0]) + DW'(pff1_r[1]) + DW'(pff1_r[2]);
      dsf2_r  <= DW'(psf1_r[0]) + DW'(psf1_r[1]) + DW'(psf1_r[2]);
      dtf2_r  <= DW'(ptf1_r[0]) + DW'(ptf1_r[1]) + DW'(ptf1_r[2]);

      mode4_r <= mode3;
      s4_r    <= s3;
      t4_r    <= t3;
      ffz4_r  <= ffz3;
      for (int i = 0; i < 3; i++) begin
        pfc0_4_r[i] <= mul_w(f3[i], c0_3);
        pfc1_4_r[i] <= mul_w(f3[i], c1_3);
      end

      mode5_r <= mode4_r;
      t5_r    <= t4_r;
      deg5_r  <= ffz4_r && (do_s4 || do_t4);
      for (int i = 0; i < 3; i++) begin
        os5_r[i]  <= do_s4 ? sat_w(XW'($signed(s4_r[i])) - trunc_shr(pfc0_4_r[i]))
                           : s4_r[i];
        acc5_r[i] <= XW'($signed(t4_r[i])) - trunc_shr(pfc1_4_r[i]);
      end

      mode6_r <= mode5_r;
      os6_r   <= os5_r;
      t6_r    <= t5_r;
      acc6_r  <= acc5_r;
      deg6_r  <= deg5_r;
      for (int i = 0; i < 3; i++) begin
        poo6_r[i] <= mul_w(os5_r[i], $signed(os5_r[i]));
        pto6_r[i] <= mul_w(t5_r[i], $signed(os5_r[i]));
      end

      mode7_r <= mode6_r;
      os7_r   <= os6_r;
      t7_r    <= t6_r;
      acc7_r  <= acc6_r;
      deg7_r  <= deg6_r;
      doo7_r  <= DW'(poo6_r[0]) + DW'(poo6_r[1]) + DW'(poo6_r[2]);
      dto7_r  <= DW'(pto6_r[0]) + DW'(pto6_r[1]) + DW'(pto6_r[2]);

      mode9_r <= mode8;
      os9_r   <= os8;
      t9_r    <= t8;
      acc9_r  <= acc8;
      deg9_r  <= deg8 || (do_t8 && ooz8);
      for (int i = 0; i < 3; i++) begin
        pc2_9_r[i] <= mul_w(os8[i], c2_8);
      end

      os_out_r  <= os9_r;
      deg_out_r <= deg9_r;
      for (int i = 0; i < 3; i++) begin
        ot_out_r[i] <= do_t9 ? sat_w($signed(acc9_r[i]) - trunc_shr(pc2_9_r[i]))
                             : t9_r[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_second_x   = $signed(os_out_r[0]);
  assign out_second_y   = $signed(os_out_r[1]);
  assign out_second_z   = $signed(os_out_r[2]);
  assign out_third_x    = $signed(ot_out_r[0]);
  assign out_third_y    = $signed(ot_out_r[1]);
  assign out_third_z    = $signed(ot_out_r[2]);
  assign out_degenerate = deg_out_r;

  // A waiting, stalled result must hold the whole pipeline.
  `GSQ_ASSERT_IMP(a_stall_holds_input, out_valid_r && out_stall, in_stall)
  // Reset leaves no result on the output.
  `GSQ_ASSERT_NXT(a_reset_clears_out, !rst_n, !out_valid_r)
  // The undefined mode performs no projection, so it cannot be degenerate.
  `GSQ_ASSERT_IMP(a_mode3_not_degen, v5_r && (mode5_r == MODE_PASS), !deg5_r)

endmodule

/* test/gram_schmidt_3d_orthogonalizer_test.sv */
// Self-checking testbench for the three-vector Gram-Schmidt orthogonaliser.
// Depends on gsq_pkg and gram_schmidt_3d_orthogonalizer; predicts every result
// in fixed point and checks each output transaction in order.
`timescale 1ns / 100ps

module gram_schmidt_3d_orthogonalizer_test import gsq_pkg::*;;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int NUM_RANDOM = 1850;

  typedef logic signed [DW-1:0] comp_t;
  typedef comp_t vec3_t [3];
  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0] mode;
    vec3_t      f, s, t;
    bit         drain;
  } job_t;

  typedef struct {
    vec3_t s, t;
    logic  degenerate;
  } ortho_t;

  localparam wide_t SAT_HI = (wide_t'(1) <<< (DW - 1)) - 1;
  localparam wide_t SAT_LO = -(wide_t'(1) <<< (DW - 1));

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  [1:0] in_mode = MODE_SECOND;
  comp_t in_first_x = '0, in_first_y = '0, in_first_z = '0;
  comp_t in_second_x = '0, in_second_y = '0, in_second_z = '0;
  comp_t in_third_x = '0, in_third_y = '0, in_third_z = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  comp_t out_second_x, out_second_y, out_second_z;
  comp_t out_third_x, out_third_y, out_third_z;
  logic  out_degenerate;

  job_t   jobs[$];
  ortho_t expected_vectors[$];
  bit     in_taken = 1'b0;
  bit     stimulus_done = 1'b0;
  int     mismatches = 0;
  int     burst_left = 0;
  int     gap_left = 0;

  gram_schmidt_3d_orthogonalizer u_dut (.*);

  always #1 clk = ~clk;

  function automatic comp_t saturate(wide_t a);
    if (a > SAT_HI) return comp_t'(SAT_HI);
    if (a < SAT_LO) return comp_t'(SAT_LO);
    return comp_t'(a);
  endfunction

  function automatic wide_t dot3(vec3_t a, vec3_t b);
    return wide_t'(a[0]) * wide_t'(b[0]) + wide_t'(a[1]) * wide_t'(b[1])
         + wide_t'(a[2]) * wide_t'(b[2]);
  endfunction

  function automatic comp_t proj_coeff(vec3_t v, vec3_t u, inout logic degen);
    wide_t uu;
    uu = dot3(u, u);
    if (uu == 0) begin
      degen = 1'b1;
      return '0;
    end
    return saturate((dot3(v, u) <<< FB) / uu);
  endfunction

  // Correction term u*c scaled back to the fixed-point format, truncated towards zero.
  function automatic wide_t scaled_term(comp_t u, comp_t c);
    wide_t p;
    p = wide_t'(u) * wide_t'(c);
    return (p < 0) ? -((-p) >>> FB) : (p >>> FB);
  endfunction

  function automatic ortho_t orthogonalise(job_t j);
    ortho_t r;
    comp_t  c, c1, c2;
    r.s = j.s;
    r.t = j.t;
    r.degenerate = 1'b0;
    if (j.mode == MODE_SECOND || j.mode == MODE_BOTH) begin
      c = proj_coeff(j.s, j.f, r.degenerate);
      for (int i = 0; i < 3; i++)
        r.s[i] = saturate(wide_t'(j.s[i]) - scaled_term(j.f[i], c));
    end
    if (j.mode == MODE_THIRD || j.mode == MODE_BOTH) begin
      c1 = proj_coeff(j.t, j.f, r.degenerate);
      c2 = proj_coeff(j.t, r.s, r.degenerate);
      for (int i = 0; i < 3; i++)
        r.t[i] = saturate(wide_t'(j.t[i]) - scaled_term(j.f[i], c1)
                          - scaled_term(r.s[i], c2));
    end
    return r;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 6))
      0: return comp_t'($urandom);
      1: return '0;
      2: return $urandom_range(0, 1) ? comp_t'(SAT_HI) : comp_t'(SAT_LO);
      3: return comp_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return comp_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic job_t make_job(logic [1:0] mode, vec3_t f, vec3_t s, vec3_t t);
    job_t j;
    j.mode = mode;
    j.f = f;
    j.s = s;
    j.t = t;
    j.drain = 1'b0;
    return j;
  endfunction

  function automatic job_t rand_job();
    job_t j;
    int   k;
    j.mode = ($urandom_range(0, 19) == 0) ? MODE_PASS : 2'($urandom_range(0, 2));
    for (int i = 0; i < 3; i++) begin
      j.f[i] = rand_comp();
      j.s[i] = rand_comp();
      j.t[i] = rand_comp();
    end
    // Occasionally make the second vector a multiple of the first, so the
    // corrected second vector collapses and the third sees a zero reference.
    if ($urandom_range(0, 9) == 0) begin
      k = $signed($urandom_range(0, 8)) - 4;
      for (int i = 0; i < 3; i++) begin
        j.f[i] = comp_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        j.s[i] = comp_t'(j.f[i] * k);
      end
    end
    j.drain = 1'b0;
    return j;
  endfunction

  // Acceptance is sampled at the rising edge; the prediction is made then.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken)
      expected_vectors.push_back(orthogonalise(make_job(in_mode,
        '{in_first_x, in_first_y, in_first_z}, '{in_second_x, in_second_y, in_second_z},
        '{in_third_x, in_third_y, in_third_z})));
  end

  always @(negedge clk) begin
    job_t j;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (jobs.size() == 0 || (jobs[0].drain && expected_vectors.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        j = jobs.pop_front();
        in_valid    <= 1'b1;
        in_mode     <= j.mode;
        in_first_x  <= j.f[0];
        in_first_y  <= j.f[1];
        in_first_z  <= j.f[2];
        in_second_x <= j.s[0];
        in_second_y <= j.s[1];
        in_second_z <= j.s[2];
        in_third_x  <= j.t[0];
        in_third_y  <= j.t[1];
        in_third_z  <= j.t[2];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // The receiver stalls on its own pattern, with one long hold-off.
  int rx_cycle = 0;
  int rx_hold = 0;
  int rx_stall_pct = 0;
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle == 1500) rx_hold = 300;
    if (rx_cycle % 200 == 0) rx_stall_pct = $urandom_range(0, 3) * 25;
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    ortho_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vectors.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with nothing expected", $time);
      end else begin
        e = expected_vectors.pop_front();
        if (out_second_x !== e.s[0] || out_second_y !== e.s[1] || out_second_z !== e.s[2]
            || out_third_x !== e.t[0] || out_third_y !== e.t[1]
            || out_third_z !== e.t[2] || out_degenerate !== e.degenerate) begin
          mismatches++;
          $display("%0t: expected second %0d %0d %0d third %0d %0d %0d deg %0b", $time,
                   e.s[0], e.s[1], e.s[2], e.t[0], e.t[1], e.t[2], e.degenerate);
          $display("%0t: actual   second %0d %0d %0d third %0d %0d %0d deg %0b", $time,
                   out_second_x, out_second_y, out_second_z, out_third_x, out_third_y,
                   out_third_z, out_degenerate);
        end
      end
    end
  end

  initial begin
    job_t j;
    comp_t mx, mn;
    mx = comp_t'(SAT_HI);
    mn = comp_t'(SAT_LO);
    for (int m = 0; m < 4; m++) begin
      jobs.push_back(make_job(2'(m), '{32'sh10000, 32'sh20000, 0}, '{32'sh30000, 0, 32'sh10000},
                              '{32'sh10000, 32'sh10000, 32'sh10000}));
      // Zero first vector: every projection onto it is dropped.
      jobs.push_back(make_job(2'(m), '{0, 0, 0}, '{32'sh10000, 5, -7}, '{-3, 32'sh8000, 9}));
    end
    // Second parallel to the first: the corrected second is zero in mode two.
    jobs.push_back(make_job(MODE_BOTH, '{32'sh10000, 32'sh10000, 0},
                            '{32'sh20000, 32'sh20000, 0}, '{1, 2, 3}));
    jobs.push_back(make_job(MODE_THIRD, '{1, 0, 0}, '{0, 0, 0}, '{mx, mx, mx}));
    jobs.push_back(make_job(MODE_SECOND, '{mx, mx, mx}, '{mn, mn, mn}, '{mx, mn, mx}));
    jobs.push_back(make_job(MODE_SECOND, '{1, 0, 0}, '{mx, mx, mn}, '{0, 0, 0}));
    jobs.push_back(make_job(MODE_BOTH, '{mn, mn, mn}, '{mx, mn, mx}, '{mn, mx, mn}));
    jobs.push_back(make_job(MODE_BOTH, '{1, -1, 1}, '{mx, mx, mx}, '{mn, mn, mn}));
    jobs.push_back(make_job(MODE_THIRD, '{mn, 0, 0}, '{0, mx, 0}, '{-1, -1, -1}));
    jobs.push_back(make_job(MODE_SECOND, '{-1, -1, -1}, '{mn, mx, 0}, '{0, 0, 0}));
    jobs.push_back(make_job(MODE_PASS, '{mx, mn, 0}, '{mn, mx, -1}, '{-1, 0, mx}));
    for (int n = 0; n < NUM_RANDOM; n++) begin
      j = rand_job();
      // The sender waits for every outstanding result now and then.
      j.drain = (n == 700) || (n == 1400);
      jobs.push_back(j);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (jobs.size() == 0 && !in_valid);
    wait (expected_vectors.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_vectors.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/gsq_pkg.sv
rtl/core/gsq_div.sv
rtl/core/gram_schmidt_3d_orthogonalizer.sv
test/gram_schmidt_3d_orthogonalizer_test.sv
